/* sv/lfps_pkg.sv */
// Shared types, constants and the microcode table of the PID steering block.
package lfps_pkg;

    localparam int SampleBits  = 10;
    localparam int SensorCount = 6;
    localparam int ThreshBits  = 10;
    localparam int GainBits    = 12;
    localparam int DutyBits    = 8;
    localparam int ErrBits     = 4;
    localparam int CfgDataBits = 12;
    localparam int CfgIdxBits  = 3;
    localparam int CmpBits     = (SampleBits > ThreshBits) ? SampleBits : ThreshBits;

    // Shared multiplier operands and product
    localparam int MulABits   = GainBits + 1;
    localparam int MulBBits   = 11;
    localparam int ProdBits   = MulABits + MulBBits;
    localparam int AccBits    = 11;
    localparam int CorrBits   = 10;
    localparam int QShift     = 8;

    // Configuration register indexes
    localparam logic [CfgIdxBits-1:0] CfgThreshold = 3'd0;
    localparam logic [CfgIdxBits-1:0] CfgGainP     = 3'd1;
    localparam logic [CfgIdxBits-1:0] CfgGainI     = 3'd2;
    localparam logic [CfgIdxBits-1:0] CfgGainD     = 3'd3;
    localparam logic [CfgIdxBits-1:0] CfgScale     = 3'd4;
    localparam logic [CfgIdxBits-1:0] CfgBaseDuty  = 3'd5;
    localparam logic [CfgIdxBits-1:0] CfgLostDuty  = 3'd6;

    localparam logic [ThreshBits-1:0] RstThreshold = 10'd850;
    localparam logic [GainBits-1:0]   RstGainP     = 12'd435;
    localparam logic [GainBits-1:0]   RstGainI     = 12'd128;
    localparam logic [GainBits-1:0]   RstGainD     = 12'd768;
    localparam logic [DutyBits-1:0]   RstScale     = 8'd15;
    localparam logic [DutyBits-1:0]   RstBaseDuty  = 8'd200;
    localparam logic [DutyBits-1:0]   RstLostDuty  = 8'd128;

    localparam logic signed [ErrBits-1:0] SensorWeight [SensorCount] =
        '{-4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3};

    localparam logic signed [ProdBits-1:0] CorrMax = 24'sd255;
    localparam logic signed [ProdBits-1:0] CorrMin = -24'sd255;
    localparam logic signed [ProdBits-1:0] TruncBias = 24'sd255;

    typedef logic [SampleBits-1:0] t_sample;

    typedef struct packed {
        logic [ThreshBits-1:0] threshold;
        logic [GainBits-1:0]   gain_p;
        logic [GainBits-1:0]   gain_i;
        logic [GainBits-1:0]   gain_d;
        logic [DutyBits-1:0]   scale;
        logic [DutyBits-1:0]   base_duty;
        logic [DutyBits-1:0]   lost_duty;
    } t_cfg;

    // Program steps
    typedef logic [2:0] t_step;
    localparam t_step StepIdle  = 3'd0;
    localparam t_step StepMulP  = 3'd1;
    localparam t_step StepMulI  = 3'd2;
    localparam t_step StepMulD  = 3'd3;
    localparam t_step StepSumD  = 3'd4;
    localparam t_step StepScale = 3'd5;
    localparam t_step StepEmit  = 3'd6;
    localparam t_step StepSpare = 3'd7;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_P,
        MS_I,
        MS_D,
        MS_SCALE
    } t_msel;

    typedef enum logic [1:0] {
        AO_HOLD,
        AO_LOAD,
        AO_ADD
    } t_aop;

    typedef struct packed {
        logic  wait_in;   // stay until an input transfer
        t_msel msel;      // multiplier operand pair, product register loads
        t_aop  aop;       // accumulator action on the truncated product
        logic  emit;      // stay until the result register is free, then load it
        t_step next;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        unique case (step)
            StepIdle:  w = '{1'b1, MS_NONE,  AO_HOLD, 1'b0, StepMulP};
            StepMulP:  w = '{1'b0, MS_P,     AO_HOLD, 1'b0, StepMulI};
            StepMulI:  w = '{1'b0, MS_I,     AO_LOAD, 1'b0, StepMulD};
            StepMulD:  w = '{1'b0, MS_D,     AO_ADD,  1'b0, StepSumD};
            StepSumD:  w = '{1'b0, MS_NONE,  AO_ADD,  1'b0, StepScale};
            StepScale: w = '{1'b0, MS_SCALE, AO_HOLD, 1'b0, StepEmit};
            StepEmit:  w = '{1'b0, MS_NONE,  AO_HOLD, 1'b1, StepIdle};
            default:   w = '{1'b0, MS_NONE,  AO_HOLD, 1'b0, StepIdle};
        endcase
        return w;
    endfunction

endpackage

/* sv/lfps_seq.sv */
// Microcode sequencer: step counter, control word fetch and handshake control.
module lfps_seq
    import lfps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    output t_ctrl o_ctrl,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output logic  o_out_load
);

    t_step r_step;
    t_step n_step;
    logic  r_out_valid;
    logic  n_out_valid;
    t_ctrl w_ctrl;
    logic  w_out_busy;

    assign w_ctrl     = ucode(r_step);
    assign w_out_busy = r_out_valid & i_out_stall;

    always_comb begin
        n_step = w_ctrl.next;
        if (w_ctrl.wait_in && !i_in_valid) begin
            n_step = r_step;
        end else if (w_ctrl.emit && w_out_busy) begin
            n_step = r_step;
        end
    end

    always_comb begin
        o_out_load  = w_ctrl.emit & ~w_out_busy;
        n_out_valid = r_out_valid & i_out_stall;
        if (o_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= StepIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ctrl      = w_ctrl;
    assign o_in_stall  = ~w_ctrl.wait_in;
    assign o_out_valid = r_out_valid;

endmodule

/* sv/lfps_dp.sv */
// Datapath: line error, shared multiplier, accumulator, clamps and result register.
module lfps_dp
    import lfps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_sample                   i_samples [SensorCount],
    input  t_cfg                      i_cfg,
    input  t_ctrl                     i_ctrl,
    input  logic                      i_take,
    input  logic                      i_load,
    output logic [DutyBits-1:0]       o_left_duty,
    output logic [DutyBits-1:0]       o_right_duty,
    output logic                      o_line_seen,
    output logic signed [ErrBits-1:0] o_line_error
);

    logic signed [ErrBits-1:0]  w_err;
    logic                       w_seen;
    logic signed [ErrBits-1:0]  r_err;
    logic                       r_seen;
    logic signed [ErrBits-1:0]  r_prev;
    logic signed [ErrBits:0]    w_esum;
    logic signed [ErrBits:0]    w_ediff;
    logic signed [MulABits-1:0] w_mul_a;
    logic signed [MulBBits-1:0] w_mul_b;
    logic signed [ProdBits-1:0] r_prod;
    logic signed [ProdBits-1:0] w_biased;
    logic signed [AccBits-1:0]  w_term;
    logic signed [AccBits-1:0]  r_acc;
    logic signed [CorrBits-1:0] w_corr;
    logic signed [CorrBits-1:0] w_left;
    logic signed [CorrBits-1:0] w_right;
    logic [DutyBits-1:0]        w_left_duty;
    logic [DutyBits-1:0]        w_right_duty;

    // Weighted sum over the sensors above threshold
    always_comb begin
        w_err  = '0;
        w_seen = 1'b0;
        for (int k = 0; k < SensorCount; k++) begin
            if (CmpBits'(i_samples[k]) > CmpBits'(i_cfg.threshold)) begin
                w_err  = w_err + SensorWeight[k];
                w_seen = 1'b1;
            end
        end
    end

    assign w_esum  = {r_err[ErrBits-1], r_err} + {r_prev[ErrBits-1], r_prev};
    assign w_ediff = {r_err[ErrBits-1], r_err} - {r_prev[ErrBits-1], r_prev};

    always_comb begin
        unique case (i_ctrl.msel)
            MS_P: begin
                w_mul_a = {1'b0, i_cfg.gain_p};
                w_mul_b = MulBBits'(r_err);
            end
            MS_I: begin
                w_mul_a = {1'b0, i_cfg.gain_i};
                w_mul_b = MulBBits'(w_esum);
            end
            MS_D: begin
                w_mul_a = {1'b0, i_cfg.gain_d};
                w_mul_b = MulBBits'(w_ediff);
            end
            MS_SCALE: begin
                w_mul_a = {{(MulABits-DutyBits){1'b0}}, i_cfg.scale};
                w_mul_b = r_acc;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Divide by 256 rounding toward zero
    assign w_biased = r_prod + (r_prod[ProdBits-1] ? TruncBias : '0);
    assign w_term   = w_biased[QShift+AccBits-1:QShift];

    always_comb begin
        if (r_prod > CorrMax) begin
            w_corr = CorrBits'(CorrMax);
        end else if (r_prod < CorrMin) begin
            w_corr = CorrBits'(CorrMin);
        end else begin
            w_corr = r_prod[CorrBits-1:0];
        end
        w_left  = $signed({2'b00, i_cfg.base_duty}) + w_corr;
        w_right = $signed({2'b00, i_cfg.base_duty}) - w_corr;
    end

    always_comb begin
        if (w_left[CorrBits-1]) begin
            w_left_duty = '0;
        end else if (w_left[CorrBits-2]) begin
            w_left_duty = '1;
        end else begin
            w_left_duty = w_left[DutyBits-1:0];
        end
        if (w_right[CorrBits-1]) begin
            w_right_duty = '0;
        end else if (w_right[CorrBits-2]) begin
            w_right_duty = '1;
        end else begin
            w_right_duty = w_right[DutyBits-1:0];
        end
        if (!r_seen) begin
            w_left_duty  = i_cfg.lost_duty;
            w_right_duty = i_cfg.lost_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_load) begin
            r_prev <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_err  <= w_err;
            r_seen <= w_seen;
        end
        if (i_ctrl.msel != MS_NONE) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        case (i_ctrl.aop)
            AO_LOAD: r_acc <= w_term;
            AO_ADD:  r_acc <= r_acc + w_term;
            default: r_acc <= r_acc;
        endcase
        if (i_load) begin
            o_left_duty  <= w_left_duty;
            o_right_duty <= w_right_duty;
            o_line_seen  <= r_seen;
            o_line_error <= r_err;
        end
    end

endmodule

/* sv/line_follow_pid_steer.sv */
// Top level of the PID steering block: configuration registers, sequencer and datapath.
//
//  channel  direction  handshake              payload
//  in       to block   i_in_valid/o_in_stall  i_sample_0 .. i_sample_5
//  out      from block o_out_valid/i_out_stall o_left_duty, o_right_duty,
//                                              o_line_seen, o_line_error
//  cfg      to block   i_cfg_we               i_cfg_index, i_cfg_data
//
// After an input transfer, six microcode steps run before the next input is taken;
// four of them share one 13x11 multiplier for the three gain terms and the scale.
// The result register holds one result; only the final step waits while it is stalled.
// Synchronous active-low reset returns the step counter to idle, empties the result
// register, clears the previous error and loads the register defaults.
module line_follow_pid_steer
    import lfps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [SampleBits-1:0]     i_sample_0,
    input  logic [SampleBits-1:0]     i_sample_1,
    input  logic [SampleBits-1:0]     i_sample_2,
    input  logic [SampleBits-1:0]     i_sample_3,
    input  logic [SampleBits-1:0]     i_sample_4,
    input  logic [SampleBits-1:0]     i_sample_5,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [DutyBits-1:0]       o_left_duty,
    output logic [DutyBits-1:0]       o_right_duty,
    output logic                      o_line_seen,
    output logic signed [ErrBits-1:0] o_line_error,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxBits-1:0]     i_cfg_index,
    input  logic [CfgDataBits-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    t_ctrl   w_ctrl;
    logic    w_take;
    logic    w_out_load;
    t_sample w_samples [SensorCount];

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RstThreshold;
            r_cfg.gain_p    <= RstGainP;
            r_cfg.gain_i    <= RstGainI;
            r_cfg.gain_d    <= RstGainD;
            r_cfg.scale     <= RstScale;
            r_cfg.base_duty <= RstBaseDuty;
            r_cfg.lost_duty <= RstLostDuty;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgThreshold: r_cfg.threshold <= i_cfg_data[ThreshBits-1:0];
                CfgGainP:     r_cfg.gain_p    <= i_cfg_data[GainBits-1:0];
                CfgGainI:     r_cfg.gain_i    <= i_cfg_data[GainBits-1:0];
                CfgGainD:     r_cfg.gain_d    <= i_cfg_data[GainBits-1:0];
                CfgScale:     r_cfg.scale     <= i_cfg_data[DutyBits-1:0];
                CfgBaseDuty:  r_cfg.base_duty <= i_cfg_data[DutyBits-1:0];
                CfgLostDuty:  r_cfg.lost_duty <= i_cfg_data[DutyBits-1:0];
                default:      r_cfg           <= r_cfg;
            endcase
        end
    end

    assign w_take = i_in_valid & ~o_in_stall;

    lfps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_ctrl      (w_ctrl),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_load  (w_out_load)
    );

    lfps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_samples    (w_samples),
        .i_cfg        (r_cfg),
        .i_ctrl       (w_ctrl),
        .i_take       (w_take),
        .i_load       (w_out_load),
        .o_left_duty  (o_left_duty),
        .o_right_duty (o_right_duty),
        .o_line_seen  (o_line_seen),
        .o_line_error (o_line_error)
    );

`ifndef SYNTHESIS
    a_one_scan_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_in_stall)
        else $error("input taken again straight after a transfer");

    a_load_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (w_ctrl.emit && o_in_stall))
        else $error("result loaded outside the emit step");

    a_lost_duties_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_line_seen) |-> (o_left_duty == o_right_duty))
        else $error("lost line with unequal duties");

    a_lost_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_line_seen) |-> (o_line_error == '0))
        else $error("lost line with non-zero error");
`endif

endmodule
